>>> rtl/tlqe_pkg.sv
// Shared constants and types for the thick line quad expander.
`timescale 1ns / 1ps
package tlqe_pkg;
	localparam int CoordW   = 32;
	localparam int WidthW   = 31;
	localparam int VnumW    = 16;
	localparam int MagW     = 31;
	localparam int SqW      = 64;
	localparam int RootW    = 32;
	localparam int ProdW    = MagW + WidthW + 1;
	localparam int QuotW    = ProdW - RootW;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_NORM  = 6'b000010,
		ST_SQRT  = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;
endpackage

>>> rtl/thick_line_quad_expander.sv
// Top level of the thick line quad expander.
// The time from segment transfer to the first corner varies with the normalising shift
// (up to 30 one-bit steps); a zero-length segment goes straight to the output.
// One segment at a time; the next transfer is taken the cycle after the last corner
// leaves. The time per segment is set mainly by the 32-step root and the two 63-step
// serial divides, and by output stalls. Reset: width 1.0, counter 0, idle.
`timescale 1ns / 1ps
module thick_line_quad_expander (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic        final_segment,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic        tex_u,
	output logic        tex_v,
	output logic [15:0] vertex_number,
	output logic        zero_length,
	output logic        batch_done,
	output logic        last
);
	tlqe_pkg::state_t state_q;

	logic [tlqe_pkg::WidthW-1:0] width_q;
	logic [tlqe_pkg::VnumW-1:0]  vcnt_q;
	logic signed [31:0] sx_q, sy_q, ex_q, ey_q;
	logic               fin_q, nx_q, ny_q, zl_q;
	logic [32:0]        mx_q, my_q;
	logic [tlqe_pkg::RootW-1:0] len_q;
	logic [tlqe_pkg::QuotW-1:0] qx_q, qy_q;
	logic [tlqe_pkg::ProdW-1:0] prod_q;
	logic               second_q;   // dividing for y
	logic [1:0]         corner_q;
	logic               ovalid_q;

	// differences, exact in 33 bits
	logic signed [32:0] dx, dy;
	assign dx = 33'(end_x) - 33'(start_x);
	assign dy = 33'(end_y) - 33'(start_y);

	// normalising shift: one bit per cycle
	logic [32:0] mmax;
	assign mmax = (mx_q > my_q) ? mx_q : my_q;

	// sqrt, started the cycle after the sum of squares is complete
	logic        sq_start, sq_done;
	logic        sq_go_q;
	logic [tlqe_pkg::RootW-1:0] sq_root;
	logic [tlqe_pkg::SqW-1:0]   sumsq;
	logic [tlqe_pkg::SqW-1:0]   sq_x_q;
	assign sumsq = sq_x_q;

	tlqe_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sumsq),
		.done(sq_done), .root(sq_root)
	);

	logic        dv_start, dv_done;
	logic [tlqe_pkg::QuotW-1:0] dv_q;
	tlqe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(prod_q),
		.divisor({len_q, 1'b0}), .done(dv_done), .quotient(dv_q)
	);

	// squares computed in turn, x then y (one multiplier, reused)
	logic        sqphase_q;
	logic [61:0] sqprod;
	assign sqprod = (sqphase_q ? my_q[30:0] : mx_q[30:0]) *
		(sqphase_q ? my_q[30:0] : mx_q[30:0]);

	logic [61:0] wprod;
	assign wprod = (second_q ? my_q[30:0] : mx_q[30:0]) * width_q;

	assign in_stall  = (state_q != tlqe_pkg::ST_IDLE) || ovalid_q;
	assign cfg_ready = 1'b1;
	assign sq_start  = sq_go_q;

	logic norm_ok;
	assign norm_ok = (mmax[32:30] == 3'b001);

	// corner arithmetic
	logic signed [33:0] px, py, bx, by, vx, vy;
	logic neg;
	assign px  = ny_q ? 34'($signed({1'b0, qy_q})) : -34'($signed({1'b0, qy_q}));
	assign py  = nx_q ? -34'($signed({1'b0, qx_q})) : 34'($signed({1'b0, qx_q}));
	assign neg = (corner_q == 2'd1) || (corner_q == 2'd2);
	assign bx  = corner_q[1] ? 34'(ex_q) : 34'(sx_q);
	assign by  = corner_q[1] ? 34'(ey_q) : 34'(sy_q);
	assign vx  = neg ? bx - px : bx + px;
	assign vy  = neg ? by - py : by + py;

	function automatic logic [31:0] sat(input logic signed [33:0] v);
		if (v > 34'sh7FFFFFFF)       sat = 32'h7FFFFFFF;
		else if (v < -34'sh80000000) sat = 32'h80000000;
		else                         sat = v[31:0];
	endfunction

	logic dv_go_q;
	assign dv_start = dv_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlqe_pkg::ST_IDLE;
			width_q   <= 31'(32'd1 << 16);
			vcnt_q    <= '0;
			ovalid_q  <= 1'b0;
			sqphase_q <= 1'b0;
			second_q  <= 1'b0;
			corner_q  <= '0;
			dv_go_q   <= 1'b0;
			sq_go_q   <= 1'b0;
		end else begin
			dv_go_q <= 1'b0;
			sq_go_q <= 1'b0;
			if (cfg_valid && cfg_ready) width_q <= cfg_data;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				tlqe_pkg::ST_IDLE: begin
					if (in_valid && !in_stall) begin
						sqphase_q <= 1'b0;
						if (dx == 33'sd0 && dy == 33'sd0) begin
							state_q <= tlqe_pkg::ST_EMIT;
						end else begin
							state_q <= tlqe_pkg::ST_NORM;
						end
					end
				end
				tlqe_pkg::ST_NORM: begin
					// shift first, then square x and then y
					if (!norm_ok) begin
						sqphase_q <= 1'b0;
					end else if (!sqphase_q) begin
						sqphase_q <= 1'b1;
					end else begin
						state_q <= tlqe_pkg::ST_SQRT;
						sq_go_q <= 1'b1;
					end
				end
				tlqe_pkg::ST_SQRT: begin
					if (sq_done) begin
						state_q  <= tlqe_pkg::ST_MUL;
						second_q <= 1'b0;
					end
				end
				tlqe_pkg::ST_MUL: begin
					dv_go_q <= 1'b1;
					state_q <= tlqe_pkg::ST_DIV;
				end
				tlqe_pkg::ST_DIV: begin
					if (dv_done) begin
						if (second_q) begin
							state_q  <= tlqe_pkg::ST_EMIT;
							corner_q <= '0;
						end else begin
							second_q <= 1'b1;
							state_q  <= tlqe_pkg::ST_MUL;
						end
					end
				end
				tlqe_pkg::ST_EMIT: begin
					if (!ovalid_q || !out_stall) begin
						ovalid_q <= 1'b1;
						if (zl_q) begin
							state_q <= tlqe_pkg::ST_IDLE;
							if (fin_q) vcnt_q <= '0;
						end else begin
							corner_q <= corner_q + 2'd1;
							vcnt_q   <= vcnt_q + 16'd1;
							if (corner_q == 2'd3) begin
								state_q <= tlqe_pkg::ST_IDLE;
								if (fin_q) vcnt_q <= '0;
							end
						end
					end
				end
				default: state_q <= tlqe_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			tlqe_pkg::ST_IDLE: begin
				if (in_valid && !in_stall) begin
					sx_q  <= start_x;
					sy_q  <= start_y;
					ex_q  <= end_x;
					ey_q  <= end_y;
					fin_q <= final_segment;
					nx_q  <= dx[32];
					ny_q  <= dy[32];
					zl_q  <= (dx == 33'sd0 && dy == 33'sd0);
					mx_q  <= dx[32] ? 33'(-dx) : 33'(dx);
					my_q  <= dy[32] ? 33'(-dy) : 33'(dy);
				end
			end
			tlqe_pkg::ST_NORM: begin
				if (mmax[32:31] != 2'b00) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
				end else if (!mmax[30]) begin
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
				end else if (!sqphase_q) begin
					sq_x_q <= 64'(sqprod);
				end else begin
					sq_x_q <= sq_x_q + 64'(sqprod);
				end
			end
			tlqe_pkg::ST_SQRT: begin
				if (sq_done) len_q <= sq_root;
			end
			tlqe_pkg::ST_MUL: begin
				prod_q <= 63'(wprod) + 63'(len_q);
			end
			tlqe_pkg::ST_DIV: begin
				if (dv_done) begin
					if (second_q) qy_q <= dv_q;
					else          qx_q <= dv_q;
				end
			end
			tlqe_pkg::ST_EMIT: begin
				if (!ovalid_q || !out_stall) begin
					zero_length   <= zl_q;
					last          <= zl_q || (corner_q == 2'd3);
					batch_done    <= fin_q && (zl_q || (corner_q == 2'd3));
					tex_u         <= zl_q ? 1'b0 : corner_q[1];
					tex_v         <= zl_q ? 1'b0 : (corner_q == 2'd0 || corner_q == 2'd3);
					vertex_number <= zl_q ? 16'd0 : vcnt_q;
					vertex_x      <= zl_q ? 32'd0 : sat(vx);
					vertex_y      <= zl_q ? 32'd0 : sat(vy);
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
endmodule

>>> rtl/tlqe_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module tlqe_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tlqe_pkg::SqW-1:0]  radicand,
	output logic                      done,
	output logic [tlqe_pkg::RootW-1:0] root
);
	logic [tlqe_pkg::SqW-1:0]   rem_q;
	logic [tlqe_pkg::SqW-1:0]   rad_q;
	logic [tlqe_pkg::RootW-1:0] root_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q;
	logic [tlqe_pkg::SqW-1:0]   trial;
	logic [tlqe_pkg::SqW-1:0]   shifted;

	assign shifted = {rem_q[tlqe_pkg::SqW-3:0], rad_q[tlqe_pkg::SqW-1 -: 2]};
	assign trial   = {{(tlqe_pkg::SqW-tlqe_pkg::RootW-2){1'b0}}, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			rad_q  <= radicand;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[tlqe_pkg::SqW-3:0], 2'b00};
			if (shifted >= trial) begin
				rem_q  <= shifted - trial;
				root_q <= {root_q[tlqe_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				root_q <= {root_q[tlqe_pkg::RootW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

>>> rtl/tlqe_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tlqe_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tlqe_pkg::ProdW-1:0] dividend,
	input  logic [tlqe_pkg::RootW:0]   divisor,
	output logic                       done,
	output logic [tlqe_pkg::QuotW-1:0] quotient
);
	logic [tlqe_pkg::ProdW-1:0] num_q;
	logic [tlqe_pkg::RootW+1:0] rem_q;
	logic [tlqe_pkg::RootW:0]   den_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q;
	logic [tlqe_pkg::RootW+1:0] sh;

	assign sh = {rem_q[tlqe_pkg::RootW:0], num_q[tlqe_pkg::ProdW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(tlqe_pkg::ProdW-1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (sh >= {1'b0, den_q}) begin
				rem_q <= sh - {1'b0, den_q};
				num_q <= {num_q[tlqe_pkg::ProdW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				num_q <= {num_q[tlqe_pkg::ProdW-2:0], 1'b0};
			end
		end
	end

	// quotient fits: magnitude below 2^31 times width below 2^31 over 2^31
	assign quotient = num_q[tlqe_pkg::QuotW-1:0];
endmodule

>>> tb/sv/tb_top.sv
// Testbench for the thick line quad expander: directed and random segments against a corner predictor.
`timescale 1ns / 1ps
module tb_top;
	// one expected corner (or zero-length marker)
	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               u;
		logic               v;
		logic [15:0]        vnum;
		logic               zl;
		logic               done;
		logic               lst;
	} corner_t;

	// Predicts the corners of each accepted segment and checks them in order.
	class quad_scoreboard;
		corner_t     pending[$];
		logic [30:0] width_q;
		logic [15:0] vcount;
		int          errors;

		function new();
			width_q = 31'h10000;
			vcount  = 0;
			errors  = 0;
		endfunction

		function automatic longint clamp32(longint a);
			if (a > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
			if (a < -64'sh80000000) return -64'sh80000000;
			return a;
		endfunction

		function automatic longint unsigned root64(longint unsigned a);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > a) b >>= 2;
			while (b != 0) begin
				if (a >= r + b) begin
					a -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_segment(logic signed [31:0] sx, logic signed [31:0] sy,
				logic signed [31:0] ex, logic signed [31:0] ey, logic fin);
			longint dx, dy, px, py, bx, by;
			longint unsigned mx, my, m, len, qx, qy;
			bit nx, ny;
			corner_t c;
			dx = longint'(ex) - longint'(sx);
			dy = longint'(ey) - longint'(sy);
			nx = dx < 0;
			ny = dy < 0;
			mx = nx ? -dx : dx;
			my = ny ? -dy : dy;
			if (mx == 0 && my == 0) begin
				c = '0;
				c.zl = 1;
				c.done = fin;
				c.lst = 1;
				pending.push_back(c);
				if (fin) vcount = 0;
				return;
			end
			m = mx > my ? mx : my;
			while (m >= (64'd1 << 31)) begin
				mx >>= 1; my >>= 1; m >>= 1;
			end
			while (m < (64'd1 << 30)) begin
				mx <<= 1; my <<= 1; m <<= 1;
			end
			len = root64(mx * mx + my * my);
			qx = (mx * width_q + len) / (len * 2);
			qy = (my * width_q + len) / (len * 2);
			px = ny ? longint'(qy) : -longint'(qy);
			py = nx ? -longint'(qx) : longint'(qx);
			for (int k = 0; k < 4; k++) begin
				bx = k < 2 ? longint'(sx) : longint'(ex);
				by = k < 2 ? longint'(sy) : longint'(ey);
				// corner order: start+perp, start-perp, end-perp, end+perp
				c.vx   = 32'(clamp32((k == 0 || k == 3) ? bx + px : bx - px));
				c.vy   = 32'(clamp32((k == 0 || k == 3) ? by + py : by - py));
				c.u    = k >= 2;
				c.v    = (k == 0 || k == 3);
				c.vnum = vcount;
				c.zl   = 0;
				c.lst  = k == 3;
				c.done = (k == 3) && fin;
				pending.push_back(c);
				vcount++;
			end
			if (fin) vcount = 0;
		endfunction

		function void check_corner(corner_t got);
			corner_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected corner, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: corner mismatch, expected x=%h y=%h u=%b v=%b n=%0d zl=%b bd=%b l=%b",
					$time, want.vx, want.vy, want.u, want.v, want.vnum, want.zl,
					want.done, want.lst);
				$display("%0t:                   actual x=%h y=%h u=%b v=%b n=%0d zl=%b bd=%b l=%b",
					$time, got.vx, got.vy, got.u, got.v, got.vnum, got.zl,
					got.done, got.lst);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [30:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
	logic final_segment = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] vertex_x, vertex_y;
	logic tex_u, tex_v, zero_length, batch_done, last;
	logic [15:0] vertex_number;

	quad_scoreboard sb = new();
	bit stim_done = 0;

	thick_line_quad_expander u_dut (.*);

	initial forever #5 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// receiver stall: random, with calm stretches of no stall
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = pick_gap();
			repeat (n + 1) @(posedge clk);
			out_stall <= (n > 0) && ($urandom_range(0, 2) == 0);
		end
	end

	// checking on every accepted corner transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_corner({vertex_x, vertex_y, tex_u, tex_v, vertex_number,
				zero_length, batch_done, last});
	end

	// valid is dropped only ahead of a gap, so back-to-back sends assign it once per step
	task automatic send_segment(logic signed [31:0] sx, logic signed [31:0] sy,
			logic signed [31:0] ex, logic signed [31:0] ey, logic fin);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid      <= 1;
		start_x       <= sx;
		start_y       <= sy;
		end_x         <= ex;
		end_y         <= ey;
		final_segment <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_segment(sx, sy, ex, ey, fin);
	endtask

	// wait until every expected corner has come, then allow a quiet spell
	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_width(logic [30:0] w);
		drain();
		cfg_valid <= 1;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.width_q = w;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 2000) - 1000;
			2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 9)
				: 32'h80000000 + $urandom_range(0, 9);
		endcase
	endfunction

	initial begin
		logic signed [31:0] sx, sy, ex, ey;
		logic [30:0] widths[6];
		widths = '{31'h0, 31'h7FFFFFFF, 31'h10000, 31'h30000, 31'h1, 31'h00400000};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset width, extremes, degenerate segments, batch end
		send_segment(0, 0, 32'sh00010000, 0, 0);
		send_segment(0, 0, 0, 32'sh00050000, 0);
		send_segment(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
		send_segment(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 0);
		send_segment(5, 5, 5, 5, 0);
		send_segment(-3, 7, -3, 7, 1);
		send_segment(1, 1, 2, 1, 0);
		send_segment(0, 0, -1, -1, 1);
		send_segment(32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 32'sh10, 0);
		send_segment(32'sh12345678, -32'sh2000, 32'sh12345678, -32'sh2000, 1);
		write_width(31'h7FFFFFFF);
		send_segment(0, 0, 32'sh00010000, 32'sh00010000, 0);
		send_segment(32'sh7FFFFF00, 32'sh80000100, 32'sh7FFFFFFF, 32'sh80000000, 1);
		write_width(31'h0);
		send_segment(100, 200, -300, 400, 1);

		// random phases over several widths; pause for a full drain between
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) write_width(31'($urandom));
			else write_width(widths[ph + 1 < 6 ? ph + 1 : 0]);
			for (int i = 0; i < 75; i++) begin
				sx = rand_coord();
				sy = rand_coord();
				if ($urandom_range(0, 9) == 0) begin
					ex = sx; ey = sy;
				end else begin
					ex = rand_coord();
					ey = rand_coord();
				end
				send_segment(sx, sy, ex, ey, $urandom_range(0, 7) == 0);
			end
		end
		// let every outstanding corner arrive
		drain();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> filelist.f
rtl/tlqe_pkg.sv
rtl/tlqe_sqrt.sv
rtl/tlqe_div.sv
rtl/thick_line_quad_expander.sv
tb/sv/tb_top.sv
